// ===== hdl/tpe_pkg.sv =====
`default_nettype none

package tpe_pkg;

	localparam int STORE_DEPTH  = 512;
	localparam int PTR_W        = $clog2(STORE_DEPTH);
	localparam int PACKET_BYTES = 188;
	localparam int POS_W        = $clog2(PACKET_BYTES);
	localparam int BEGIN_W      = POS_W + 1;
	localparam int PID_W        = 13;

	localparam logic [7:0]         TS_SYNC     = 8'h47;
	localparam logic [PID_W-1:0]   NULL_PID    = 13'h1FFF;
	localparam logic [POS_W-1:0]   LAST_POS    = POS_W'(PACKET_BYTES - 1);
	localparam logic [POS_W-1:0]   POS_PID_HI  = POS_W'(1);
	localparam logic [POS_W-1:0]   POS_PID_LO  = POS_W'(2);
	localparam logic [POS_W-1:0]   POS_CC      = POS_W'(3);
	localparam logic [POS_W-1:0]   POS_AF_LEN  = POS_W'(4);
	localparam logic [BEGIN_W-1:0] BEGIN_PLAIN = BEGIN_W'(4);
	localparam logic [BEGIN_W-1:0] BEGIN_AF    = BEGIN_W'(5);

	// ring pointer increment with wrap at the store depth
	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] q;
		q = (p == PTR_W'(STORE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
		return q;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/tpe_outer_if.sv =====
`default_nettype none

interface tpe_outer_if;
	logic       valid;
	logic       ready;
	logic [7:0] outer_byte;
	logic       outer_start;

	modport source (output valid, output outer_byte, output outer_start, input ready);
	modport sink   (input valid, input outer_byte, input outer_start, output ready);
endinterface

`default_nettype wire

// ===== hdl/tpe_inner_if.sv =====
`default_nettype none

interface tpe_inner_if;
	logic       valid;
	logic       ready;
	logic [7:0] inner_byte;
	logic       inner_first;
	logic       inner_last;

	modport source (output valid, output inner_byte, output inner_first, output inner_last,
		input ready);
	modport sink   (input valid, input inner_byte, input inner_first, input inner_last,
		output ready);
endinterface

`default_nettype wire

// ===== hdl/ts_tunnel_packet_extractor_core.sv =====
`default_nettype none

// tunnel packet extractor
// outer: one byte of an aligned outer transport stream per request, with outer_start
//   on byte 0 of each 188-byte packet (the position also wraps by itself after 188)
// inner: bytes of complete 188-byte inner packets gathered from the payload of the
//   packets on tunnel_pid, with inner_first on the sync byte and inner_last on the
//   188th byte
// cfg_we / cfg_wdata: writes tunnel_pid; the null pid turns extraction off
// throughput: one outer request per cycle unless stalled; the header decision and one
//   byte store write happen at the accept edge, the drain read uses the second port
// an accepted outer request that releases an inner byte passes that byte on to inner
//   through the read stage (store read), then the output register
// at most one inner request is released per outer request, and only once a whole
//   inner packet is committed, so inner never runs ahead of outer
// stall: an inner stall fills the output register, then the read stage; outer
//   ready drops only when both hold a byte
// reset: pointers, counters and output valid clear at once; tunnel_pid comes up as
//   the null pid; the byte store is not cleared and needs no clearing pass, since
//   only committed entries are ever read

module ts_tunnel_packet_extractor_core (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [tpe_pkg::PID_W-1:0] cfg_wdata,
	tpe_outer_if.sink                    outer,
	tpe_inner_if.source                  inner
);

	// configuration
	logic [tpe_pkg::PID_W-1:0] tunnel_pid_q;

	// header parse state
	logic [tpe_pkg::POS_W-1:0]   pos_q;
	logic [4:0]                  pid_hi_q;
	logic                        take_q;
	logic [tpe_pkg::BEGIN_W-1:0] begin_q;
	logic [3:0]                  prev_cc_q;
	logic                        prev_cc_valid_q;
	logic                        locked_q;

	// byte store pointers
	logic [tpe_pkg::PTR_W-1:0] wr_ptr_q;
	logic [tpe_pkg::PTR_W-1:0] commit_q;
	logic [tpe_pkg::PTR_W-1:0] rd_ptr_q;
	logic [tpe_pkg::POS_W-1:0] gather_cnt_q;
	logic [tpe_pkg::POS_W-1:0] drain_cnt_q;

	// read stage and output register
	logic       valid_s1;
	logic       first_s1;
	logic       last_s1;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_first_q;
	logic       out_last_q;

	// next-state values
	logic [tpe_pkg::POS_W-1:0]   pos;
	logic [tpe_pkg::POS_W-1:0]   pos_n;
	logic [4:0]                  pid_hi_n;
	logic                        take_n;
	logic [tpe_pkg::BEGIN_W-1:0] begin_n;
	logic [3:0]                  prev_cc_n;
	logic                        prev_cc_valid_n;
	logic                        locked_n;
	logic [tpe_pkg::PTR_W-1:0]   wr_ptr_n;
	logic [tpe_pkg::PTR_W-1:0]   commit_n;
	logic [tpe_pkg::PTR_W-1:0]   rd_ptr_n;
	logic [tpe_pkg::POS_W-1:0]   gather_cnt_n;
	logic                        mem_we;
	logic [7:0]                  mem_rdata;

	logic                      accept;
	logic                      drain;
	logic                      s1_adv;
	logic [tpe_pkg::PID_W-1:0] pid;
	logic [1:0]                afc;
	logic [3:0]                cc;
	logic [7:0]                b;

	assign b      = outer.outer_byte;
	assign drain  = (rd_ptr_q != commit_q);
	assign s1_adv = valid_s1 && (!out_valid_q || inner.ready);
	// take a new byte while the read stage is empty or moving on
	assign outer.ready = !valid_s1 || s1_adv;
	assign accept      = outer.valid && outer.ready;

	assign pos      = outer.outer_start ? '0 : pos_q;
	assign pos_n    = (pos == tpe_pkg::LAST_POS) ? '0 : pos + tpe_pkg::POS_W'(1);
	assign rd_ptr_n = drain ? tpe_pkg::ptr_next(rd_ptr_q) : rd_ptr_q;
	assign pid      = {pid_hi_q, b};
	assign afc      = b[5:4];
	assign cc       = b[3:0];

	always_comb begin
		pid_hi_n        = pid_hi_q;
		take_n          = take_q;
		begin_n         = begin_q;
		prev_cc_n       = prev_cc_q;
		prev_cc_valid_n = prev_cc_valid_q;
		locked_n        = locked_q;
		wr_ptr_n        = wr_ptr_q;
		commit_n        = commit_q;
		gather_cnt_n    = gather_cnt_q;
		mem_we          = 1'b0;

		if (pos == '0) begin
			take_n = 1'b0;
		end else if (pos == tpe_pkg::POS_PID_HI) begin
			pid_hi_n = b[4:0];
		end else if (pos == tpe_pkg::POS_PID_LO) begin
			take_n = (tunnel_pid_q != tpe_pkg::NULL_PID) && (pid == tunnel_pid_q);
		end else if (pos == tpe_pkg::POS_CC) begin
			// payload present and a counter that is not a repeat
			if (take_q && afc[0] && (!prev_cc_valid_q || cc != prev_cc_q)) begin
				// a gap drops the partial inner packet
				if (locked_q && prev_cc_valid_q && cc != prev_cc_q + 4'd1) begin
					locked_n     = 1'b0;
					wr_ptr_n     = commit_q;
					gather_cnt_n = '0;
				end
				prev_cc_n       = cc;
				prev_cc_valid_n = 1'b1;
				begin_n         = afc[1] ? tpe_pkg::BEGIN_AF : tpe_pkg::BEGIN_PLAIN;
			end else begin
				take_n = 1'b0;
			end
		end else begin
			if (pos == tpe_pkg::POS_AF_LEN && begin_q == tpe_pkg::BEGIN_AF) begin
				begin_n = tpe_pkg::BEGIN_AF + tpe_pkg::BEGIN_W'(b);
			end
			if (take_q && {1'b0, pos} >= begin_n) begin
				if (gather_cnt_q == '0 && b != tpe_pkg::TS_SYNC) begin
					// hunting for an inner sync byte
					locked_n = 1'b0;
				end else begin
					if (gather_cnt_q == '0) begin
						locked_n = 1'b1;
					end
					if (tpe_pkg::ptr_next(wr_ptr_q) == rd_ptr_n) begin
						// store full: drop the partial packet and this byte
						wr_ptr_n     = commit_q;
						gather_cnt_n = '0;
					end else begin
						mem_we   = 1'b1;
						wr_ptr_n = tpe_pkg::ptr_next(wr_ptr_q);
						if (gather_cnt_q == tpe_pkg::LAST_POS) begin
							commit_n     = wr_ptr_n;
							gather_cnt_n = '0;
						end else begin
							gather_cnt_n = gather_cnt_q + tpe_pkg::POS_W'(1);
						end
					end
				end
			end
		end
	end

	// a write never lands on the entry read in the same cycle: the full check keeps
	// the write pointer off the read pointer, so no forwarding is needed
	tpe_ram #(
		.WIDTH (8),
		.DEPTH (tpe_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (accept && mem_we),
		.waddr (wr_ptr_q),
		.wdata (b),
		.re    (accept && drain),
		.raddr (rd_ptr_q),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tunnel_pid_q <= tpe_pkg::NULL_PID;
		end else if (cfg_we) begin
			tunnel_pid_q <= cfg_wdata;
		end
	end

	// parse and pointer state advances once per accepted outer byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q           <= '0;
			pid_hi_q        <= '0;
			take_q          <= 1'b0;
			begin_q         <= tpe_pkg::BEGIN_PLAIN;
			prev_cc_q       <= '0;
			prev_cc_valid_q <= 1'b0;
			locked_q        <= 1'b1;
			wr_ptr_q        <= '0;
			commit_q        <= '0;
			rd_ptr_q        <= '0;
			gather_cnt_q    <= '0;
			drain_cnt_q     <= '0;
		end else if (accept) begin
			pos_q           <= pos_n;
			pid_hi_q        <= pid_hi_n;
			take_q          <= take_n;
			begin_q         <= begin_n;
			prev_cc_q       <= prev_cc_n;
			prev_cc_valid_q <= prev_cc_valid_n;
			locked_q        <= locked_n;
			wr_ptr_q        <= wr_ptr_n;
			commit_q        <= commit_n;
			rd_ptr_q        <= rd_ptr_n;
			gather_cnt_q    <= gather_cnt_n;
			// commits come in whole packets, so a byte count marks the boundaries
			if (drain) begin
				drain_cnt_q <= (drain_cnt_q == tpe_pkg::LAST_POS) ? '0
					: drain_cnt_q + tpe_pkg::POS_W'(1);
			end
		end
	end

	// read stage: store data arrives in the cycle after the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			first_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else if (accept) begin
			valid_s1 <= drain;
			first_s1 <= (drain_cnt_q == '0);
			last_s1  <= (drain_cnt_q == tpe_pkg::LAST_POS);
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (inner.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_byte_q  <= mem_rdata;
			out_first_q <= first_s1;
			out_last_q  <= last_s1;
		end
	end

	assign inner.valid       = out_valid_q;
	assign inner.inner_byte  = out_byte_q;
	assign inner.inner_first = out_first_q;
	assign inner.inner_last  = out_last_q;

`ifndef NO_ASSERTIONS
	// a held read stage keeps its byte until the output register takes it
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_adv |=> valid_s1)
		else $error("read stage byte lost");

	// an empty store sits on an inner packet boundary
	a_drain_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_ptr_q == commit_q) |-> (drain_cnt_q == '0))
		else $error("drain count off a packet boundary");

	// store write and drain read never share an entry
	a_no_collision: assert property (@(posedge clk) disable iff (!arst_n)
		accept && mem_we && drain |-> wr_ptr_q != rd_ptr_q)
		else $error("store write hits the read entry");

	// a byte read into an empty stage leaves it the next cycle if the output can take it
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept && drain && !valid_s1 && (!out_valid_q || inner.ready) |=> s1_adv)
		else $error("read stage did not advance");
`endif

endmodule

`default_nettype wire

// ===== hdl/tpe_ram.sv =====
`default_nettype none

module tpe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire
